// ----- src/rtvne_pkg.sv -----
`default_nettype none

package rtvne_pkg;

  // Number of color channels, each handled by its own lane.
  localparam int unsigned ChannelCount = 3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  ThreshReset = 8'd217;
  localparam logic [23:0] BudgetReset = 24'd6000000;

  // Output bits that one full pair may cost, checked before the pair is handled.
  localparam logic [24:0] PairCost = 25'd6;

  // Configuration register indexes.
  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgBudget    = 2'd1;

  // Channel codes on the result port.
  localparam logic [1:0] ChRed   = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  // What one lane reports about its channel for the current pixel.
  typedef struct packed {
    logic cur_bit;
    logic held_bit;
    logic differ;
  } lane_out_t;

  // Results of one pixel pair: one entry per channel that emits.
  typedef struct packed {
    logic [ChannelCount-1:0] mask;
    logic [ChannelCount-1:0] first;
    logic [ChannelCount-1:0] second;
  } pair_bundle_t;

endpackage

`default_nettype wire

// ----- src/rtvne_lane.sv -----
`default_nettype none

module rtvne_lane (
  input  wire logic                clk,
  input  wire logic [7:0]          pixel_byte,
  input  wire logic [7:0]          threshold,
  input  wire logic                latch_en,
  output rtvne_pkg::lane_out_t     lane_out
);

  logic cur_bit;
  logic held;

  // Threshold the channel byte to one bit.
  assign cur_bit = (pixel_byte >= threshold);

  // Hold the bit of the even pixel until its partner arrives.
  always_ff @(posedge clk) begin
    if (latch_en) begin
      held <= cur_bit;
    end
  end

  assign lane_out.cur_bit  = cur_bit;
  assign lane_out.held_bit = held;
  assign lane_out.differ   = held ^ cur_bit;

endmodule

`default_nettype wire

// ----- src/rtvne_merge.sv -----
`default_nettype none

module rtvne_merge (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire rtvne_pkg::pair_bundle_t push_bundle,
  output logic                         space,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   channel,
  output logic                         first_bit,
  output logic                         second_bit,
  output logic                         run_end
);

  rtvne_pkg::pair_bundle_t nb;
  rtvne_pkg::pair_bundle_t ob;
  logic                    nb_valid;
  logic [rtvne_pkg::ChannelCount-1:0] sel_bit;
  logic [rtvne_pkg::ChannelCount-1:0] mask_after;
  logic                    out_fire;

  // The waiting bundle takes a new request only when it is empty.
  assign space     = !nb_valid;
  assign out_valid = (ob.mask != '0);
  assign out_fire  = out_valid && out_ready;

  // Pick the lowest emitting channel: red, then green, then blue.
  always_comb begin
    sel_bit = '0;
    channel = rtvne_pkg::ChBlue;
    priority if (ob.mask[0]) begin
      sel_bit[0] = 1'b1;
      channel    = rtvne_pkg::ChRed;
    end else if (ob.mask[1]) begin
      sel_bit[1] = 1'b1;
      channel    = rtvne_pkg::ChGreen;
    end else begin
      sel_bit[2] = 1'b1;
      channel    = rtvne_pkg::ChBlue;
    end
  end

  assign first_bit  = |(ob.first & sel_bit);
  assign second_bit = |(ob.second & sel_bit);
  // The last result of a pair is the one whose bit is the only one left.
  assign run_end    = ((ob.mask & ~sel_bit) == '0);

  assign mask_after = out_fire ? (ob.mask & ~sel_bit) : ob.mask;

  // Drain the output bundle and refill it from the waiting one.
  always_ff @(posedge clk) begin
    if (rst) begin
      nb_valid <= 1'b0;
      ob.mask  <= '0;
    end else begin
      if ((mask_after == '0) && nb_valid) begin
        ob       <= nb;
        nb_valid <= 1'b0;
      end else begin
        ob.mask <= mask_after;
        if (push) begin
          nb       <= push_bundle;
          nb_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (nb_valid && !out_valid) |=> out_valid)
    else $error("waiting bundle was not moved to the output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !nb_valid)
    else $error("request pushed into a full bundle register");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_end) |-> $onehot(ob.mask))
    else $error("run end flagged with results still pending");
`endif

endmodule

`default_nettype wire

// ----- src/rgb_threshold_von_neumann_extractor_core.sv -----
`default_nettype none

// Thresholds each RGB pixel to three bits and pairs consecutive pixels of a
// frame; each channel whose two bits differ yields one result (red, green,
// blue order), with run_end on the last result of the pair. Three lanes
// threshold the channels in parallel and a merge stage serializes their
// results. An input request is taken whenever the one-pair holding
// register is free, so even pixels and pairs that emit nothing pass at one
// per cycle while it stays free; the output channel delivers one result per
// cycle while out_ready is high, and a pair that emits anything keeps the
// input waiting until it moves out of the holding register into the output
// bundle, once the results of the previous pair have all been taken.
// frame_start clears pairing, the bit count and the halt; output stops for
// the frame once the count plus six would exceed output_budget.
module rgb_threshold_von_neumann_extractor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       channel,
  output logic             first_bit,
  output logic             second_bit,
  output logic             run_end
);

  logic [7:0]  bit_threshold;
  logic [23:0] output_budget;
  logic        pair_phase;
  logic [23:0] emitted_count;
  logic        halted;

  logic        in_fire;
  logic        phase_eff;
  logic [23:0] count_eff;
  logic        halt_eff;
  logic        odd_pixel;
  logic        over_budget;
  logic        emit;
  logic        push;
  logic [1:0]  emit_num;
  logic [23:0] count_next;

  logic [7:0] lane_byte [rtvne_pkg::ChannelCount];
  rtvne_pkg::lane_out_t    lane_res [rtvne_pkg::ChannelCount];
  rtvne_pkg::pair_bundle_t bundle;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= rtvne_pkg::ThreshReset;
      output_budget <= rtvne_pkg::BudgetReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtvne_pkg::CfgThreshold: bit_threshold <= cfg_data[7:0];
        rtvne_pkg::CfgBudget:    output_budget <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;

  // Frame start resets pairing, count and halt before the pixel is used.
  assign phase_eff = frame_start ? 1'b0  : pair_phase;
  assign count_eff = frame_start ? '0    : emitted_count;
  assign halt_eff  = frame_start ? 1'b0  : halted;

  assign lane_byte[0] = red;
  assign lane_byte[1] = green;
  assign lane_byte[2] = blue;

  // One thresholding lane per color channel.
  for (genvar g = 0; g < rtvne_pkg::ChannelCount; g++) begin : g_lane
    rtvne_lane u_lane (
      .clk        (clk),
      .pixel_byte (lane_byte[g]),
      .threshold  (bit_threshold),
      .latch_en   (in_fire && !phase_eff),
      .lane_out   (lane_res[g])
    );
    assign bundle.mask[g]   = lane_res[g].differ;
    assign bundle.first[g]  = lane_res[g].held_bit;
    assign bundle.second[g] = lane_res[g].cur_bit;
  end

  // Budget check on every odd pixel of a frame that is not halted.
  assign odd_pixel   = in_fire && phase_eff;
  assign over_budget = ({1'b0, count_eff} + rtvne_pkg::PairCost) > {1'b0, output_budget};
  assign emit        = odd_pixel && !halt_eff && !over_budget;
  assign push        = emit && (bundle.mask != '0);

  assign emit_num   = {1'b0, bundle.mask[0]} + {1'b0, bundle.mask[1]}
                    + {1'b0, bundle.mask[2]};
  assign count_next = emit ? (count_eff + {21'b0, emit_num, 1'b0}) : count_eff;

  // Pairing, count and halt state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase    <= 1'b0;
      emitted_count <= '0;
      halted        <= 1'b0;
    end else if (in_fire) begin
      pair_phase    <= !phase_eff;
      emitted_count <= count_next;
      halted        <= halt_eff || (odd_pixel && over_budget);
    end
  end

  // Serialize the lane results onto the output channel.
  rtvne_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (bundle),
    .space       (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .first_bit   (first_bit),
    .second_bit  (second_bit),
    .run_end     (run_end)
  );

`ifndef SYNTHESIS
  a_count_even: assert property (@(posedge clk) disable iff (rst)
    emitted_count[0] == 1'b0)
    else $error("emitted bit count became odd");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !frame_start && halted) |-> !push)
    else $error("results produced while halted");

  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (halted && !(in_fire && frame_start)) |=> halted)
    else $error("halt cleared without a frame start");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

  // One pixel request and one emitted bit pair.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [1:0] channel;
    logic       first_bit;
    logic       second_bit;
    logic       run_end;
  } vn_pair_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Register indexes that the block must ignore.
  localparam logic [1:0] CfgSpare2 = 2'd2;
  localparam logic [1:0] CfgSpare3 = 2'd3;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rtvne_pkg::CfgThreshold;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  channel;
  logic        first_bit;
  logic        second_bit;
  logic        run_end;

  rgb_threshold_von_neumann_extractor_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .channel(channel),
    .first_bit(first_bit),
    .second_bit(second_bit),
    .run_end(run_end)
  );

  always #4 clk = ~clk;

  pixel_t     pixel_q[$];
  vn_pair_t   pair_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         error_count = 0;
  int         cycle_count = 0;

  // Shadow copy of the configuration and the pairing state.
  logic [7:0]  thr_level = rtvne_pkg::ThreshReset;
  logic [23:0] bit_budget = rtvne_pkg::BudgetReset;
  logic [2:0]  held_lanes = '0;
  logic        odd_next = 1'b0;
  logic [23:0] bits_sent = '0;
  logic        frame_halted = 1'b0;

  // Works out the bit pairs that one accepted pixel releases.
  task automatic predict_pairs(input pixel_t px);
    logic [2:0] cur;
    vn_pair_t   found[$];
    vn_pair_t   res;
    if (px.frame_start) begin
      odd_next = 1'b0;
      bits_sent = '0;
      frame_halted = 1'b0;
    end
    cur = {px.blue >= thr_level, px.green >= thr_level, px.red >= thr_level};
    if (!odd_next) begin
      held_lanes = cur;
      odd_next = 1'b1;
    end else begin
      odd_next = 1'b0;
      if (!frame_halted) begin
        if ({1'b0, bits_sent} + 25'd6 > {1'b0, bit_budget}) begin
          frame_halted = 1'b1;
        end else begin
          for (int ch = 0; ch < 3; ch++) begin
            if (held_lanes[ch] != cur[ch]) begin
              res.channel = (ch == 0) ? rtvne_pkg::ChRed :
                            (ch == 1) ? rtvne_pkg::ChGreen : rtvne_pkg::ChBlue;
              res.first_bit = held_lanes[ch];
              res.second_bit = cur[ch];
              res.run_end = 1'b0;
              found.push_back(res);
              bits_sent = bits_sent + 24'd2;
            end
          end
          if (found.size() > 0) found[found.size() - 1].run_end = 1'b1;
          foreach (found[i]) pair_q.push_back(found[i]);
        end
      end
    end
  endtask

  // Pixel driver: holds each request until it is taken.
  always @(posedge clk) begin
    int gap_pct;
    pixel_t px;
    gap_pct = (idle_mode == IDLE_SENDER) ? 81 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pairs({red, green, blue, frame_start});
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          px = pixel_q.pop_front();
          red <= px.red;
          green <= px.green;
          blue <= px.blue;
          frame_start <= px.frame_start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken result with the oldest expectation.
  always @(posedge clk) begin
    int stall_pct;
    vn_pair_t want;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 81 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pair_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result channel %0d first %0b second %0b end %0b",
                   $time, channel, first_bit, second_bit, run_end);
        end else begin
          want = pair_q.pop_front();
          if (want != {channel, first_bit, second_bit, run_end}) begin
            error_count++;
            $display("%0t: expected channel %0d first %0b second %0b end %0b, got %0d %0b %0b %0b",
                     $time, want.channel, want.first_bit, want.second_bit, want.run_end,
                     channel, first_bit, second_bit, run_end);
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fs);
    pixel_q.push_back({r, g, b, fs});
  endtask

  // Register write, also applied to the shadow configuration.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rtvne_pkg::CfgThreshold) thr_level = val[7:0];
    else if (idx == rtvne_pkg::CfgBudget) bit_budget = val;
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || pair_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Channel byte that is random, at or above the threshold, below it, or at the threshold or one below it.
  function automatic logic [7:0] pick_level(input logic [7:0] thr);
    case ($urandom_range(3, 0))
      0: pick_level = 8'($urandom_range(255, 0));
      1: pick_level = 8'($urandom_range(255, thr));
      2: pick_level = (thr == 0) ? 8'd0 : 8'($urandom_range(thr - 1, 0));
      default: pick_level = ($urandom_range(1, 0) != 0) ? thr : thr - 8'd1;
    endcase
  endfunction

  // Random frames under one setting and idle pattern.
  task automatic random_phase(input logic [7:0] thr, input logic [23:0] budget,
                              input idle_mode_t mode, input int count);
    logic fs;
    write_reg(rtvne_pkg::CfgThreshold, {16'd0, thr});
    write_reg(rtvne_pkg::CfgBudget, budget);
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) || ($urandom_range(13, 0) == 0);
      add_pixel(pick_level(thr), pick_level(thr), pick_level(thr), fs);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: all three, two, no and one channel differing,
    // a held pixel dropped by a frame start, then a trailing even pixel.
    add_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd217, 8'd216, 8'd0, 1'b0);
    add_pixel(8'd216, 8'd217, 8'd0, 1'b0);
    add_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    drain();

    // A budget of one pair: the second pair halts the frame.
    write_reg(rtvne_pkg::CfgThreshold, 24'd128);
    write_reg(rtvne_pkg::CfgBudget, 24'd6);
    idle_mode = IDLE_SENDER;
    add_pixel(8'd200, 8'd0, 8'd200, 1'b1);
    add_pixel(8'd0, 8'd200, 8'd0, 1'b0);
    add_pixel(8'd200, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd200, 8'd200, 8'd200, 1'b0);
    drain();

    // Raising the budget and writing unused indexes leave the halt in place.
    write_reg(rtvne_pkg::CfgBudget, 24'hFFFFFF);
    write_reg(CfgSpare2, 24'd0);
    write_reg(CfgSpare3, 24'hFFFFFF);
    idle_mode = IDLE_RECEIVER;
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drain();

    random_phase(8'd217, 24'hFFFFFF, IDLE_NONE, 60);
    random_phase(8'd0, 24'd6000000, IDLE_SENDER, 20);
    random_phase(8'd255, 24'd40, IDLE_SENDER, 50);
    random_phase(8'd128, 24'd6000000, IDLE_RECEIVER, 60);
    random_phase(8'($urandom_range(255, 0)), 24'($urandom_range(60, 6)), IDLE_BOTH, 60);
    random_phase(8'd1, 24'd0, IDLE_NONE, 20);
    random_phase(8'd200, 24'd7, IDLE_BOTH, 30);
    random_phase(8'($urandom_range(254, 1)), 24'hFFFFFF, IDLE_BOTH, 40);

    if (pair_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
